/* src/noth_pkg.sv */
// shared types, constants and arithmetic helpers for the nearest-of-two haversine block
`default_nettype none
package noth_pkg;

  localparam int CW       = 34;
  localparam int UW       = 31;
  localparam int REM_W    = 61;
  localparam int MAG_W    = 25;
  localparam int ANG_W    = 32;
  localparam int DIST_W   = 23;
  localparam int MUL_LO_W = 31;
  localparam int MUL_W    = 61;

  typedef logic signed [CW-1:0] cw_t;
  typedef logic [UW-1:0]        unit_t;
  typedef logic [REM_W-1:0]     rem_t;
  typedef logic [MAG_W-1:0]     mag_t;
  typedef logic [ANG_W-1:0]     ang_t;
  typedef logic [DIST_W-1:0]    dist_t;

  typedef enum logic [1:0] {
    REG_FIRST_LAT,
    REG_FIRST_LON,
    REG_SECOND_LAT,
    REG_SECOND_LON
  } cfg_reg_t;

  localparam unit_t ONE_Q30     = 31'h4000_0000;
  localparam ang_t  PI_Q30      = 32'd3373259426;
  localparam unit_t HALF_PI_Q30 = 31'd1686629713;
  localparam cw_t   GAIN_INV    = 34'sh026DD3B6A;
  localparam logic signed [23:0] LAT_LIMIT = 24'sd5898240;
  localparam logic signed [24:0] LON_LIMIT = 25'sd11796480;
  localparam dist_t DIST_LIMIT  = 23'd5123840;
  localparam logic [12:0] EARTH_R_KM = 13'd6371;

  // ceil(pi_q30 * 2^52 / divisor) for half and full angle conversion
  localparam logic [127:0] DEG_HALF_WIDE = (({96'd0, PI_Q30} << 33) + 128'd44) / 128'd45;
  localparam logic [127:0] DEG_FULL_WIDE = (({96'd0, PI_Q30} << 34) + 128'd44) / 128'd45;
  localparam logic [MUL_W-1:0] DEG_HALF_MUL = DEG_HALF_WIDE[MUL_W-1:0];
  localparam logic [MUL_W-1:0] DEG_FULL_MUL = DEG_FULL_WIDE[MUL_W-1:0];

  function automatic cw_t atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return cw_t'(v);
  endfunction

  function automatic logic signed [23:0] sat_lat(input logic signed [23:0] v);
    logic signed [23:0] r;
    if (v > LAT_LIMIT) r = LAT_LIMIT;
    else if (v < -LAT_LIMIT) r = -LAT_LIMIT;
    else r = v;
    return r;
  endfunction

  function automatic logic signed [24:0] sat_lon(input logic signed [24:0] v);
    logic signed [24:0] r;
    if (v > LON_LIMIT) r = LON_LIMIT;
    else if (v < -LON_LIMIT) r = -LON_LIMIT;
    else r = v;
    return r;
  endfunction

  // q30 product with round half up
  function automatic unit_t mulq(input unit_t a, input unit_t b);
    logic [62:0] p;
    p = 63'(a) * 63'(b) + 63'h2000_0000;
    return p[60:30];
  endfunction

  function automatic unit_t clamp_unit(input cw_t v);
    unit_t r;
    if (v < 0) r = '0;
    else if (v > cw_t'(ONE_Q30)) r = ONE_Q30;
    else r = v[UW-1:0];
    return r;
  endfunction

  function automatic unit_t clamp_half_pi(input cw_t v);
    unit_t r;
    if (v < 0) r = '0;
    else if (v > cw_t'(HALF_PI_Q30)) r = HALF_PI_Q30;
    else r = v[UW-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/noth_cordic_cell.sv */
// one registered cordic iteration, rotation or vectoring
`default_nettype none
module noth_cordic_cell #(
  parameter int IDX       = 0,
  parameter bit VECTORING = 1'b0
) (
  input  wire               clk,
  input  wire               en,
  input  noth_pkg::cw_t     x_i,
  input  noth_pkg::cw_t     y_i,
  input  noth_pkg::cw_t     z_i,
  output noth_pkg::cw_t     x_o,
  output noth_pkg::cw_t     y_o,
  output noth_pkg::cw_t     z_o
);

  localparam noth_pkg::cw_t AT = noth_pkg::atan_entry(5'(IDX));

  noth_pkg::cw_t x_r, y_r, z_r;
  noth_pkg::cw_t x_nxt, y_nxt, z_nxt;
  noth_pkg::cw_t dx, dy;
  logic sigma;

  always_comb begin
    dx = y_i >>> IDX;
    dy = x_i >>> IDX;
    sigma = VECTORING ? y_i[noth_pkg::CW-1] : !z_i[noth_pkg::CW-1];
    if (sigma) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - AT;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + AT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule
`default_nettype wire

/* src/noth_sqrt_cell.sv */
// one registered digit of the restoring square root
`default_nettype none
module noth_sqrt_cell #(
  parameter int K = 0
) (
  input  wire                clk,
  input  wire                en,
  input  noth_pkg::rem_t     rem_i,
  input  noth_pkg::unit_t    root_i,
  output noth_pkg::rem_t     rem_o,
  output noth_pkg::unit_t    root_o
);

  noth_pkg::rem_t  rem_r, rem_nxt;
  noth_pkg::unit_t root_r, root_nxt;
  logic [63:0] trial;
  logic [63:0] cand;

  always_comb begin
    trial = (64'(root_i) << 1) + (64'd1 << K);
    cand  = trial << K;
    if (64'(rem_i) >= cand) begin
      rem_nxt  = rem_i - cand[noth_pkg::REM_W-1:0];
      root_nxt = root_i | (noth_pkg::unit_t'(1) << K);
    end else begin
      rem_nxt  = rem_i;
      root_nxt = root_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule
`default_nettype wire

/* src/noth_dist.sv */
// distance pipeline from the query to one candidate position
`default_nettype none
module noth_dist #(
  parameter int CORDIC_STEPS = 20
) (
  input  wire                     clk,
  input  wire                     en,
  input  wire logic signed [23:0] q_lat,
  input  wire logic signed [24:0] q_lon,
  input  wire logic signed [23:0] c_lat,
  input  wire logic signed [24:0] c_lon,
  output noth_pkg::dist_t         dist_o
);

  localparam int N = CORDIC_STEPS;
  localparam int SQ = noth_pkg::UW;

  logic signed [25:0] dlat, dlon;
  noth_pkg::mag_t mag_nxt [4];
  noth_pkg::mag_t mag_r [4];
  logic [55:0] pl_r [4];
  logic [54:0] ph_r [4];
  noth_pkg::ang_t ang_r [4];
  noth_pkg::unit_t zin_r [4];

  noth_pkg::cw_t rx [4][N+1];
  noth_pkg::cw_t ry [4][N+1];
  noth_pkg::cw_t rz [4][N+1];

  noth_pkg::unit_t m1_r, m2_r, m3_r, m4_r, m1d_r, a_r;
  logic [31:0] a_sum;

  noth_pkg::rem_t  sq_rem [2][SQ+1];
  noth_pkg::unit_t sq_root [2][SQ+1];

  noth_pkg::cw_t vx [N+1];
  noth_pkg::cw_t vy [N+1];
  noth_pkg::cw_t vz [N+1];

  noth_pkg::unit_t zc;
  logic [43:0] dprod;
  noth_pkg::dist_t dist_r, dist_nxt;

  // magnitudes: lat diff, lon diff (half angles), query lat, candidate lat
  always_comb begin
    dlat = 26'(c_lat) - 26'(q_lat);
    dlon = 26'(c_lon) - 26'(q_lon);
    mag_nxt[0] = dlat[25] ? 25'(-dlat) : dlat[24:0];
    mag_nxt[1] = dlon[25] ? 25'(-dlon) : dlon[24:0];
    mag_nxt[2] = q_lat[23] ? 25'(-26'(q_lat)) : 25'(q_lat);
    mag_nxt[3] = c_lat[23] ? 25'(-26'(c_lat)) : 25'(c_lat);
  end

  for (genvar c = 0; c < 4; c++) begin : g_conv
    localparam logic [noth_pkg::MUL_W-1:0] CM =
      (c < 2) ? noth_pkg::DEG_HALF_MUL : noth_pkg::DEG_FULL_MUL;
    logic [86:0] sum;

    always_comb begin
      sum = (87'(ph_r[c]) << noth_pkg::MUL_LO_W) + 87'(pl_r[c]) + (87'd1 << 51);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mag_r[c] <= mag_nxt[c];
        pl_r[c]  <= 56'(mag_r[c]) * 56'(CM[noth_pkg::MUL_LO_W-1:0]);
        ph_r[c]  <= 55'(mag_r[c]) * 55'(CM[noth_pkg::MUL_W-1:noth_pkg::MUL_LO_W]);
        ang_r[c] <= sum[83:52];
        zin_r[c] <= (ang_r[c] > 32'(noth_pkg::HALF_PI_Q30)) ?
                    31'(noth_pkg::PI_Q30 - ang_r[c]) : ang_r[c][30:0];
      end
    end

    assign rx[c][0] = noth_pkg::GAIN_INV;
    assign ry[c][0] = '0;
    assign rz[c][0] = noth_pkg::cw_t'(zin_r[c]);

    for (genvar i = 0; i < N; i++) begin : g_rot
      noth_cordic_cell #(.IDX(i), .VECTORING(1'b0)) u_cell (
        .clk (clk),
        .en  (en),
        .x_i (rx[c][i]),
        .y_i (ry[c][i]),
        .z_i (rz[c][i]),
        .x_o (rx[c][i+1]),
        .y_o (ry[c][i+1]),
        .z_o (rz[c][i+1])
      );
    end
  end

  // haversine term
  always_comb begin
    a_sum = 32'(m1d_r) + 32'(m4_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r  <= noth_pkg::mulq(noth_pkg::clamp_unit(ry[0][N]), noth_pkg::clamp_unit(ry[0][N]));
      m2_r  <= noth_pkg::mulq(noth_pkg::clamp_unit(rx[2][N]), noth_pkg::clamp_unit(rx[3][N]));
      m3_r  <= noth_pkg::mulq(noth_pkg::clamp_unit(ry[1][N]), noth_pkg::clamp_unit(ry[1][N]));
      m4_r  <= noth_pkg::mulq(m2_r, m3_r);
      m1d_r <= m1_r;
      a_r   <= (a_sum > 32'(noth_pkg::ONE_Q30)) ? noth_pkg::ONE_Q30 : a_sum[30:0];
    end
  end

  assign sq_rem[0][0]  = {a_r, 30'd0};
  assign sq_rem[1][0]  = {31'(noth_pkg::ONE_Q30 - a_r), 30'd0};
  assign sq_root[0][0] = '0;
  assign sq_root[1][0] = '0;

  for (genvar s = 0; s < 2; s++) begin : g_sq
    for (genvar j = 0; j < SQ; j++) begin : g_dig
      noth_sqrt_cell #(.K(SQ - 1 - j)) u_cell (
        .clk    (clk),
        .en     (en),
        .rem_i  (sq_rem[s][j]),
        .root_i (sq_root[s][j]),
        .rem_o  (sq_rem[s][j+1]),
        .root_o (sq_root[s][j+1])
      );
    end
  end

  // half central angle
  assign vx[0] = noth_pkg::cw_t'(sq_root[1][SQ]);
  assign vy[0] = noth_pkg::cw_t'(sq_root[0][SQ]);
  assign vz[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_vec
    noth_cordic_cell #(.IDX(i), .VECTORING(1'b1)) u_cell (
      .clk (clk),
      .en  (en),
      .x_i (vx[i]),
      .y_i (vy[i]),
      .z_i (vz[i]),
      .x_o (vx[i+1]),
      .y_o (vy[i+1]),
      .z_o (vz[i+1])
    );
  end

  always_comb begin
    zc = noth_pkg::clamp_half_pi(vz[N]);
    dprod = 44'(zc) * 44'(noth_pkg::EARTH_R_KM) + (44'd1 << 20);
    dist_nxt = (dprod[43:21] > noth_pkg::DIST_LIMIT) ? noth_pkg::DIST_LIMIT : dprod[43:21];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= dist_nxt;
    end
  end

  assign dist_o = dist_r;

endmodule
`default_nettype wire

/* src/nearest_of_two_haversine.sv */
// throughput: one word per cycle while not held, through five cordic chains of CORDIC_STEPS
// cells and two 31-cell square root chains per candidate, all advancing together
// the pipeline holds only while the output register holds an untaken word and another finished word waits behind it
// reset: synchronous active low, clears candidate registers to zero and empties the pipeline
`default_nettype none
module nearest_of_two_haversine #(
  parameter int CORDIC_STEPS = 20
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire logic signed [23:0] in_query_lat,
  input  wire logic signed [24:0] in_query_lon,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic                    out_pick,
  output logic [22:0]             out_dist_first,
  output logic [22:0]             out_dist_second,
  input  wire                     cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [24:0]        cfg_data
);

  localparam int LAT = 39 + 2 * CORDIC_STEPS;

  logic signed [23:0] first_lat_r, second_lat_r;
  logic signed [24:0] first_lon_r, second_lon_r;
  logic [LAT-1:0] vld_r, vld_nxt;
  logic adv;
  logic out_valid_r;
  logic pick_r;
  noth_pkg::dist_t dist_first_r, dist_second_r;
  noth_pkg::dist_t dist_first, dist_second;
  logic signed [23:0] q_lat_s;
  logic signed [24:0] q_lon_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_lat_r  <= '0;
      first_lon_r  <= '0;
      second_lat_r <= '0;
      second_lon_r <= '0;
    end else if (cfg_we) begin
      unique case (noth_pkg::cfg_reg_t'(cfg_index))
        noth_pkg::REG_FIRST_LAT:  first_lat_r  <= cfg_data[23:0];
        noth_pkg::REG_FIRST_LON:  first_lon_r  <= cfg_data;
        noth_pkg::REG_SECOND_LAT: second_lat_r <= cfg_data[23:0];
        noth_pkg::REG_SECOND_LON: second_lon_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv      = !(vld_r[LAT-1] && out_valid_r && !out_ready);
  assign in_ready = adv;
  assign vld_nxt  = {vld_r[LAT-2:0], in_valid};
  assign q_lat_s  = noth_pkg::sat_lat(in_query_lat);
  assign q_lon_s  = noth_pkg::sat_lon(in_query_lon);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  noth_dist #(.CORDIC_STEPS(CORDIC_STEPS)) u_first (
    .clk    (clk),
    .en     (adv),
    .q_lat  (q_lat_s),
    .q_lon  (q_lon_s),
    .c_lat  (noth_pkg::sat_lat(first_lat_r)),
    .c_lon  (noth_pkg::sat_lon(first_lon_r)),
    .dist_o (dist_first)
  );

  noth_dist #(.CORDIC_STEPS(CORDIC_STEPS)) u_second (
    .clk    (clk),
    .en     (adv),
    .q_lat  (q_lat_s),
    .q_lon  (q_lon_s),
    .c_lat  (noth_pkg::sat_lat(second_lat_r)),
    .c_lon  (noth_pkg::sat_lon(second_lon_r)),
    .dist_o (dist_second)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      pick_r        <= !(dist_first < dist_second);
      dist_first_r  <= dist_first;
      dist_second_r <= dist_second;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pick        = pick_r;
  assign out_dist_first  = dist_first_r;
  assign out_dist_second = dist_second_r;

endmodule
`default_nettype wire

/* src/noth_chk.sv */
// port checker for the nearest-of-two haversine block and its bind
`default_nettype none
module noth_chk (
  input wire                     clk,
  input wire                     rst_n,
  input wire                     in_ready,
  input wire                     out_valid,
  input wire                     out_ready,
  input wire                     out_pick,
  input wire logic [22:0]        out_dist_first,
  input wire logic [22:0]        out_dist_second
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pick) && $stable(out_dist_first)
      && $stable(out_dist_second))
    else $error("output word changed while stalled");

  a_pick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pick == (out_dist_first >= out_dist_second))
    else $error("pick disagrees with distances");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dist_first <= noth_pkg::DIST_LIMIT
      && out_dist_second <= noth_pkg::DIST_LIMIT)
    else $error("distance above limit");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

endmodule

bind nearest_of_two_haversine noth_chk u_chk (.*);
`default_nettype wire
